// ===== hw/rtl/hmq_pkg.sv =====
// shared types and constants of the binary min-heap priority queue
package hmq_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned PairW   = 2 * KeyW;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 8;
  // 1-based node index; covers child indexes of the deepest level for up to 65536 keys
  localparam int unsigned IdxW    = 18;

  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  // sibling pair of one level: lo is the left (even) node, hi the right one
  typedef struct packed {
    key_t hi;
    key_t lo;
  } pair_t;

  // operation walking down the chain of level cells
  typedef struct packed {
    logic            vld;
    op_e             op;
    key_t            key;   // moving key
    logic [IdxW-1:0] idx;   // node the key sits at, 1-based
    logic [IdxW-1:0] cnt;   // keys held after the operation
    logic [IdxW-1:0] path;  // insert target, leading one at the top bit
  } tok_t;

  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic done;
    logic hit;
    key_t val;
  } cell_sts_t;

endpackage

// ===== hw/rtl/binary_min_heap_queue_top.sv =====
// binary min-heap priority queue: controller and chain of level cells
// Priority queue of signed 32-bit keys, up to HEAP_DEPTH of them, held as a
// binary min-heap with one cell per tree level; each cell keeps its level in a
// small ram of sibling pairs. Put opcode (0 insert, 1 pop) on s_tuser_i and the
// key on s_tdata_i; every transfer in gives one transfer out with the popped
// key (zero unless a pop succeeds), the status on m_tuser_o (0 ok, 1 pop on
// empty, 2 insert when full) and the key count. One item is worked at a time.
// A refused item goes straight to the output; an accepted insert or pop sifts
// its key down through the levels that it visits (at most clog2(HEAP_DEPTH + 1)
// of them), each level costing one ram read of the child pair and one compare
// and write back.
// The block accepts the next item while the last result waits on the output.
module binary_min_heap_queue_top #(
  parameter int unsigned HEAP_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,  // [31:0] key_in
  input  logic        s_tuser_i,  // [0] opcode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,  // [31:0] key_out, [39:32] fill_count
  output logic [1:0]  m_tuser_o   // [1:0] status
);

  import hmq_pkg::*;

  localparam int unsigned Levels = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CntW   = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RD_LAST = 6'b000010,
    ST_RD_ROOT = 6'b000100,
    ST_LAUNCH  = 6'b001000,
    ST_SIFT    = 6'b010000,
    ST_HOLD    = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  op_e             op_q, op_d;
  key_t            mov_q, mov_d, key_q, key_d;
  status_e         sts_q, sts_d;
  logic            m_valid_q, m_valid_d;
  logic [39:0]     m_data_q, m_data_d;
  logic [1:0]      m_user_q, m_user_d;

  rd_req_t   bus;
  tok_t      tok   [Levels+1];
  rd_req_t   rdq   [Levels+1];
  pair_t     pairs [Levels+1];
  cell_sts_t csts  [Levels];
  logic      done_any;
  key_t      last_val;

  // place the leading one of the insert target at the top bit
  function automatic logic [IdxW-1:0] norm_path(logic [IdxW-1:0] t);
    int sh;
    sh = 0;
    for (int i = 0; i < IdxW; i++) begin
      if (t[i]) begin
        sh = IdxW - 1 - i;
      end
    end
    return t << sh;
  endfunction

  assign rdq[0]        = '0;
  assign pairs[Levels] = '0;

  for (genvar g = 0; g < Levels; g++) begin : g_cell
    hmq_cell #(
      .LVL (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .bus_i   (bus),
      .nb_rd_i (rdq[g]),
      .nb_rd_o (rdq[g+1]),
      .kid_i   (pairs[g+1]),
      .pair_o  (pairs[g]),
      .sts_o   (csts[g])
    );
  end

  always_comb begin
    done_any = 1'b0;
    last_val = '0;
    for (int i = 0; i < Levels; i++) begin
      done_any = done_any | csts[i].done;
      if (csts[i].hit) begin
        last_val = last_val | csts[i].val;
      end
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    mov_d     = mov_q;
    key_d     = key_q;
    sts_d     = sts_q;
    bus       = '0;
    tok[0]    = '0;
    m_valid_d = m_valid_q && !m_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          op_d  = op_e'(s_tuser_i);
          key_d = '0;
          sts_d = STS_OK;
          if (op_e'(s_tuser_i) == OP_INSERT) begin
            if (cnt_q == CntW'(HEAP_DEPTH)) begin
              sts_d   = STS_FULL;
              state_d = ST_HOLD;
            end else begin
              cnt_d   = cnt_q + CntW'(1);
              mov_d   = s_tdata_i;
              state_d = ST_RD_ROOT;
            end
          end else begin
            if (cnt_q == '0) begin
              sts_d   = STS_EMPTY;
              state_d = ST_HOLD;
            end else begin
              cnt_d   = cnt_q - CntW'(1);
              state_d = ST_RD_LAST;
            end
          end
        end
      end
      ST_RD_LAST: begin
        // old last entry sits at node count + 1 after the decrement
        bus.re  = 1'b1;
        bus.idx = IdxW'(cnt_q) + IdxW'(1);
        state_d = ST_RD_ROOT;
      end
      ST_RD_ROOT: begin
        if (op_q == OP_POP) begin
          mov_d = last_val;
        end
        bus.re  = 1'b1;
        bus.idx = IdxW'(1);
        state_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (op_q == OP_POP) begin
          key_d = pairs[0].lo;
        end
        if ((op_q == OP_POP) && (cnt_q == '0)) begin
          state_d = ST_HOLD;
        end else begin
          tok[0].vld  = 1'b1;
          tok[0].op   = op_q;
          tok[0].key  = mov_q;
          tok[0].idx  = IdxW'(1);
          tok[0].cnt  = IdxW'(cnt_q);
          tok[0].path = norm_path(IdxW'(cnt_q));
          state_d     = ST_SIFT;
        end
      end
      ST_SIFT: begin
        if (done_any) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {FillW'(cnt_q), key_q};
          m_user_d  = sts_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      op_q      <= OP_INSERT;
      mov_q     <= '0;
      key_q     <= '0;
      sts_q     <= STS_OK;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      op_q      <= op_d;
      mov_q     <= mov_d;
      key_q     <= key_d;
      sts_q     <= sts_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

endmodule

// ===== hw/rtl/hmq_ram.sv =====
// generic single-write, single-read ram with registered read data
module hmq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hmq_cell.sv =====
// one heap level: its node pairs in a ram and the compare step of a sift
module hmq_cell #(
  parameter int unsigned LVL = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hmq_pkg::tok_t      tok_i,
  output hmq_pkg::tok_t      tok_o,
  input  hmq_pkg::rd_req_t   bus_i,
  input  hmq_pkg::rd_req_t   nb_rd_i,
  output hmq_pkg::rd_req_t   nb_rd_o,
  input  hmq_pkg::pair_t     kid_i,
  output hmq_pkg::pair_t     pair_o,
  output hmq_pkg::cell_sts_t sts_o
);

  import hmq_pkg::*;

  localparam int unsigned RamD = (LVL < 2) ? 1 : ((1 << LVL) >> 1);
  localparam int unsigned AW   = (RamD > 1) ? $clog2(RamD) : 1;

  tok_t            tok_q;
  logic            busy_q, ph_q, hit_q, hsel_q;
  pair_t           rd;
  logic            bus_hit, ram_re, we, act_b, half, lv, rv, pick_r, pass;
  logic [IdxW-1:0] ridx, lidx;
  logic [AW-1:0]   raddr, waddr;
  key_t            ov, pv, wval;
  pair_t           wdata;

  // broadcast reads address a node of this level only
  assign bus_hit = bus_i.re && ((bus_i.idx >> LVL) == IdxW'(1));
  assign ridx    = bus_hit ? bus_i.idx : nb_rd_i.idx;
  assign ram_re  = bus_hit || nb_rd_i.re;
  assign raddr   = (LVL < 2) ? '0 : AW'(ridx >> 1);
  assign waddr   = (LVL < 2) ? '0 : AW'(tok_q.idx >> 1);

  hmq_ram #(
    .WIDTH (PairW),
    .DEPTH (RamD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      hit_q <= bus_hit;
      if (tok_i.vld) begin
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
      end else if (busy_q && !ph_q) begin
        ph_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      tok_q <= tok_i;
    end
    if (bus_hit) begin
      hsel_q <= (LVL == 0) ? 1'b0 : bus_i.idx[0];
    end
  end

  // first step (ph_q low): fetch the children pair from the next level
  assign nb_rd_o.re  = busy_q && !ph_q;
  assign nb_rd_o.idx = lidx;

  // second step (ph_q high): decide what stays at this node and what moves on
  always_comb begin
    act_b  = busy_q && ph_q;
    half   = (LVL == 0) ? 1'b0 : tok_q.idx[0];
    ov     = half ? rd.hi : rd.lo;
    lidx   = tok_q.idx << 1;
    lv     = lidx <= tok_q.cnt;
    rv     = (lidx | IdxW'(1)) <= tok_q.cnt;
    pick_r = rv && !($signed(kid_i.lo) < $signed(kid_i.hi));
    pv     = pick_r ? kid_i.hi : kid_i.lo;
    tok_o  = tok_q;
    pass   = 1'b0;
    wval   = tok_q.key;
    case (tok_q.op)
      OP_POP: begin
        if (lv && ($signed(pv) < $signed(tok_q.key))) begin
          wval      = pv;
          pass      = 1'b1;
          tok_o.idx = lidx | IdxW'(pick_r);
        end
      end
      OP_INSERT: begin
        if (tok_q.idx != tok_q.cnt) begin
          pass       = 1'b1;
          tok_o.idx  = lidx | IdxW'(tok_q.path[IdxW-2]);
          tok_o.path = tok_q.path << 1;
          if ($signed(tok_q.key) < $signed(ov)) begin
            tok_o.key = ov;
          end else begin
            wval = ov;
          end
        end
      end
      default: begin
        pass = 1'b0;
      end
    endcase
    tok_o.vld = act_b && pass;
    we        = act_b;
    wdata     = half ? pair_t'{hi: wval, lo: rd.lo} : pair_t'{hi: rd.hi, lo: wval};
  end

  assign pair_o     = rd;
  assign sts_o.done = act_b && !pass;
  assign sts_o.hit  = hit_q;
  assign sts_o.val  = hsel_q ? rd.hi : rd.lo;

endmodule
